/* src/msgd_pkg.sv */
// Shared types, constants and helper functions for the momentum SGD update block.
// Used by msgd_vel_store and momentum_sgd_update; depends on nothing else.
package msgd_pkg;

  localparam int IDX_W   = 12;
  localparam int DATA_W  = 32;
  localparam int COEF_W  = 24;
  localparam int CFG_IDX_W = 2;

  // Depth of the velocity store. It must be a power of two, so that the
  // element index wraps onto a slot by dropping its upper bits.
  localparam int NUM_ELEMS = 4096;
  localparam int ADDR_W    = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;

  localparam logic [COEF_W:0]   ONE_Q24  = 25'h100_0000;
  localparam logic [COEF_W-1:0] HALF_Q24 = 24'h80_0000;

  localparam logic [COEF_W-1:0] RATE_RESET     = 24'd16777;
  localparam logic [COEF_W-1:0] MOMENTUM_RESET = 24'd8388608;
  localparam logic [COEF_W-1:0] DECAY_RESET    = 24'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_RATE = 2'd0,
    REG_MOMENTUM     = 2'd1,
    REG_DECAY        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]         elem_index;
    logic signed [DATA_W-1:0] weight_in;
    logic signed [DATA_W-1:0] grad_in;
    logic                     pass_end;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] weight_out;
    logic [IDX_W-1:0]         index_out;
  } out_req_t;

  typedef struct packed {
    logic                     en;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] data;
  } mem_wr_t;

  localparam logic signed [DATA_W+2:0] SAT_HI = 35'sd2147483647;
  localparam logic signed [DATA_W+2:0] SAT_LO = -35'sd2147483648;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    return ADDR_W'(idx);
  endfunction

  // Clamp a 35-bit signed value into the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+2:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/msgd_vel_store.sv */
// Velocity store: one-write, one-read memory with registered read data and a
// clearing pass after reset. Depends on msgd_pkg.
module msgd_vel_store
  import msgd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic signed [DATA_W-1:0] rd_data,
  input  mem_wr_t                  wr,
  output logic                     busy
);

  logic signed [DATA_W-1:0] mem [NUM_ELEMS];
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     clr_busy_r;
  logic [ADDR_W-1:0]        clr_addr_r;
  logic                     we;
  logic [ADDR_W-1:0]        wa;
  logic signed [DATA_W-1:0] wd;

  // The clearing pass walks the store once after reset, one slot per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(NUM_ELEMS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign we = clr_busy_r | wr.en;
  assign wa = clr_busy_r ? clr_addr_r : wr.addr;
  assign wd = clr_busy_r ? '0 : wr.data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

/* src/momentum_sgd_update.sv */
// Top level of the momentum SGD update block: pipeline control, coefficient
// registers, rate decay and the velocity arithmetic. Depends on msgd_pkg and
// msgd_vel_store.
//
// The block takes one request per cycle while in_stall is low and presents one
// result per request, in order. Requests go through four registered stages:
// velocity read, the two coefficient products, subtract-round-saturate with
// write-back to the store, and the saturated weight add. A request whose index
// maps to the same store slot as the request accepted just before it waits while
// that request is in stage 0, since its old velocity is the result of that
// request's subtract stage; all other request orders run at full rate. A stall
// on the result side holds the whole pipeline. After reset the velocity store is
// cleared in a pass over all NUM_ELEMS (4096) slots, during which in_stall is
// high; configuration writes are taken during that pass. Writing the initial
// rate also reloads the current rate. A request with pass_end set still uses the
// rate before the decay; the decayed rate applies from the next request on.
module momentum_sgd_update
  import msgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_req_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0]     cfg_wdata
);

  logic                     adv;
  logic                     hazard;
  logic                     in_fire;
  logic                     store_busy;
  logic signed [DATA_W-1:0] rd_data;
  mem_wr_t                  mem_wr;

  logic [COEF_W-1:0] rate_r;
  logic [COEF_W-1:0] momentum_r;
  logic [COEF_W-1:0] decay_r;
  logic [COEF_W:0]   keep;
  logic [2*COEF_W:0] decay_prod;
  logic [2*COEF_W:0] decay_sum;

  // Stage 0: request registered, velocity read data arriving.
  logic                     s0_valid_r;
  logic [ADDR_W-1:0]        s0_slot_r;
  logic [IDX_W-1:0]         s0_idx_r;
  logic signed [DATA_W-1:0] s0_w_r;
  logic signed [DATA_W-1:0] s0_g_r;
  logic                     s0_last_r;
  logic signed [DATA_W-1:0] v_sel;
  logic signed [DATA_W+COEF_W:0] pm;
  logic signed [DATA_W+COEF_W:0] pg;

  // Stage 1: products registered.
  logic                     s1_valid_r;
  logic [ADDR_W-1:0]        s1_slot_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic signed [DATA_W-1:0] s1_w_r;
  logic signed [DATA_W+COEF_W:0] s1_pm_r;
  logic signed [DATA_W+COEF_W:0] s1_pg_r;
  logic signed [DATA_W+COEF_W+1:0] diff;
  logic signed [DATA_W+COEF_W+2:0] diff_rnd;
  logic signed [DATA_W-1:0] nv;

  // Stage 2: new velocity registered.
  logic                     s2_valid_r;
  logic [ADDR_W-1:0]        s2_slot_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic signed [DATA_W-1:0] s2_w_r;
  logic signed [DATA_W-1:0] s2_nv_r;
  logic signed [DATA_W:0]   wsum;

  logic     out_valid_r;
  out_req_t out_data_r;

  assign adv     = !out_valid_r || !out_stall;
  assign hazard  = s0_valid_r && (slot_of(in_data.elem_index) == s0_slot_r);
  assign in_stall = !adv || store_busy || hazard;
  assign in_fire = in_valid && !in_stall;

  msgd_vel_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (slot_of(in_data.elem_index)),
    .rd_data (rd_data),
    .wr      (mem_wr),
    .busy    (store_busy)
  );

  // Rate decay: rate * (1 - decay), rounded to nearest.
  assign keep       = ONE_Q24 - {1'b0, decay_r};
  assign decay_prod = (2*COEF_W+1)'(rate_r) * (2*COEF_W+1)'(keep);
  assign decay_sum  = decay_prod + (2*COEF_W+1)'(HALF_Q24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= RATE_RESET;
      momentum_r <= MOMENTUM_RESET;
      decay_r    <= DECAY_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INITIAL_RATE: rate_r     <= cfg_wdata;
          REG_MOMENTUM:     momentum_r <= cfg_wdata;
          REG_DECAY:        decay_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (adv && s0_valid_r && s0_last_r) begin
        rate_r <= decay_sum[2*COEF_W-1:COEF_W];
      end
    end
  end

  // The store read misses the write made by the request that sat in stage 1
  // when this one was accepted; that value now sits in stage 2.
  assign v_sel = (s2_valid_r && (s2_slot_r == s0_slot_r)) ? s2_nv_r : rd_data;
  assign pm    = (DATA_W+COEF_W+1)'(v_sel) *
                 (DATA_W+COEF_W+1)'($signed({1'b0, momentum_r}));
  assign pg    = (DATA_W+COEF_W+1)'(s0_g_r) *
                 (DATA_W+COEF_W+1)'($signed({1'b0, rate_r}));

  // Round to nearest with ties up is a floor after adding one half LSB.
  assign diff     = (DATA_W+COEF_W+2)'(s1_pm_r) - (DATA_W+COEF_W+2)'(s1_pg_r);
  assign diff_rnd = (DATA_W+COEF_W+3)'(diff) + (DATA_W+COEF_W+3)'($signed({1'b0, HALF_Q24}));
  assign nv       = sat32(diff_rnd[DATA_W+COEF_W+2:COEF_W]);

  assign mem_wr.en   = adv && s1_valid_r;
  assign mem_wr.addr = s1_slot_r;
  assign mem_wr.data = nv;

  assign wsum = (DATA_W+1)'(s2_w_r) + (DATA_W+1)'(s2_nv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r  <= in_fire;
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_fire) begin
        s0_slot_r <= slot_of(in_data.elem_index);
        s0_idx_r  <= in_data.elem_index;
        s0_w_r    <= in_data.weight_in;
        s0_g_r    <= in_data.grad_in;
        s0_last_r <= in_data.pass_end;
      end
      s1_slot_r <= s0_slot_r;
      s1_idx_r  <= s0_idx_r;
      s1_w_r    <= s0_w_r;
      s1_pm_r   <= pm;
      s1_pg_r   <= pg;
      s2_slot_r <= s1_slot_r;
      s2_idx_r  <= s1_idx_r;
      s2_w_r    <= s1_w_r;
      s2_nv_r   <= nv;
      out_data_r.weight_out <= sat32((DATA_W+3)'(wsum));
      out_data_r.index_out  <= s2_idx_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // Back-to-back requests on one slot must have been split by a bubble.
  a_no_adjacent_slot: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && s1_valid_r |-> s0_slot_r != s1_slot_r)
    else $error("two requests on one slot in adjacent stages");

  // Nothing is in flight while the store is being cleared.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    store_busy |-> !in_fire && !s1_valid_r && !mem_wr.en)
    else $error("request in flight during the clearing pass");

  // A held output freezes the stage occupancy.
  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({s0_valid_r, s1_valid_r, s2_valid_r}))
    else $error("pipeline moved while the output was stalled");

  // The rate changes only by a configuration write or a pass end.
  a_rate_change: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_we && (cfg_index == REG_INITIAL_RATE)) && !(adv && s0_valid_r && s0_last_r)
    |=> $stable(rate_r))
    else $error("learning rate changed without cause");
`endif

endmodule
